// ----- rtl/core/dltq_pkg.sv -----
// Package for the delta-list timer queue: operation and status codes,
// controller states and fixed field widths. No dependencies.
package dltq_pkg;

    localparam int IdW    = 16;
    localparam int DeltaW = 16;
    localparam int MaxResults = 16;
    localparam int NW = $clog2(MaxResults + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_RELEASED = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IN_RD,
        S_IN_CMP,
        S_IN_SRD,
        S_IN_SWR,
        S_IN_PUT,
        S_IN_FIX,
        S_CA_RD,
        S_CA_CMP,
        S_CA_SRD,
        S_CA_SWR,
        S_TK_RD,
        S_TK_CHK,
        S_TK_FIN,
        S_RESP
    } t_state;

endpackage

// ----- rtl/core/delta_list_timer_queue_top.sv -----
// Delta-list timer queue: one circular entry memory walked by a sequencer.
// Depends on dltq_pkg.
//
// Channel   Dir  Signals                   Contents
// s (in)    in   i_s_tvalid/o_s_tready     tuser: opcode; tdata: thread_id, delay_ticks
// m (out)   out  o_m_tvalid/i_m_tready     tuser: status; tdata: released_id; tlast
//
// One item at a time. An insert walks the stored entries to its place, shifts the
// later entries up, writes the new entry and then adjusts its follower, if any; a
// cancel walks to the match and shifts the later entries down. A tick checks and
// releases entries from the head. Reset (synchronous, active low) empties the list
// at once. A stalled output holds the sequencer only where a further result must
// be loaded.
module delta_list_timer_queue_top
    import dltq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [15:0] thread_id, [31:16] delay_ticks
    input  logic [1:0]  i_s_tuser,  // [1:0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [15:0] released_id
    output logic [1:0]  o_m_tuser,  // [1:0] status
    output logic        o_m_tlast
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0] DepthX = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
    localparam logic [NW-1:0] MaxN = NW'(MaxResults);

    logic [IdW+DeltaW-1:0] mem [QUEUE_DEPTH];
    logic [IdW+DeltaW-1:0] r_rdat;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_i, n_i;
    logic [IdW-1:0] r_id, n_id;
    logic [DeltaW-1:0] r_d, n_d;
    logic [IdW-1:0] r_fthr, n_fthr;
    logic [DeltaW-1:0] r_fdel, n_fdel;
    logic [IdW-1:0] r_rid, n_rid;
    t_status r_rst, n_rst;
    logic [NW-1:0] r_n, n_n;
    logic r_hp, n_hp;
    logic r_first, n_first;
    logic [IdW-1:0] r_pend, n_pend;

    logic r_ov, n_ov;
    logic [IdW-1:0] r_oid, n_oid;
    t_status r_ost, n_ost;
    logic r_olast, n_olast;

    logic we, re;
    logic [AW-1:0] wa, ra;
    logic [IdW+DeltaW-1:0] wd;

    logic slot_free;
    logic [IdW-1:0] rd_thr;
    logic [DeltaW-1:0] rd_del, del_eff;

    // Logical list position to memory address, wrapping at the depth.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(idx);
        if (sum >= DepthX) begin
            sum = sum - DepthX;
        end
        return sum[AW-1:0];
    endfunction

    assign slot_free = !r_ov || i_m_tready;
    assign rd_thr = r_rdat[IdW+DeltaW-1:DeltaW];
    assign rd_del = r_rdat[DeltaW-1:0];
    assign del_eff = (r_first && rd_del != '0) ? rd_del - 1'b1 : rd_del;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_oid;
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rdat <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_head  <= '0;
            r_ov    <= 1'b0;
            r_hp    <= 1'b0;
            r_first <= 1'b0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_ov    <= n_ov;
            r_hp    <= n_hp;
            r_first <= n_first;
            r_n     <= n_n;
        end
        r_pos   <= n_pos;
        r_i     <= n_i;
        r_id    <= n_id;
        r_d     <= n_d;
        r_fthr  <= n_fthr;
        r_fdel  <= n_fdel;
        r_rid   <= n_rid;
        r_rst   <= n_rst;
        r_pend  <= n_pend;
        r_oid   <= n_oid;
        r_ost   <= n_ost;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_head  = r_head;
        n_pos   = r_pos;
        n_i     = r_i;
        n_id    = r_id;
        n_d     = r_d;
        n_fthr  = r_fthr;
        n_fdel  = r_fdel;
        n_rid   = r_rid;
        n_rst   = r_rst;
        n_n     = r_n;
        n_hp    = r_hp;
        n_first = r_first;
        n_pend  = r_pend;
        n_ov    = r_ov && !i_m_tready;
        n_oid   = r_oid;
        n_ost   = r_ost;
        n_olast = r_olast;
        we = 1'b0;
        re = 1'b0;
        wa = '0;
        ra = '0;
        wd = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_id  = i_s_tdata[IdW-1:0];
                    n_rid = i_s_tdata[IdW-1:0];
                    n_d   = (i_s_tdata[31:16] == '0) ? DeltaW'(1) : i_s_tdata[31:16];
                    n_pos = '0;
                    n_rst = ST_DONE;
                    case (t_op'(i_s_tuser))
                        OP_INSERT: begin
                            if (r_cnt == DepthC) begin
                                n_rst   = ST_FULL;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_IN_RD;
                            end
                        end
                        OP_TICK: begin
                            if (r_cnt == '0) begin
                                n_rid   = '0;
                                n_state = S_RESP;
                            end else begin
                                n_n     = '0;
                                n_hp    = 1'b0;
                                n_first = 1'b1;
                                n_state = S_TK_RD;
                            end
                        end
                        OP_CANCEL: n_state = S_CA_RD;
                        default:   n_state = S_RESP;
                    endcase
                end
            end

            S_IN_RD: begin
                if (r_pos == r_cnt) begin
                    n_i     = r_cnt;
                    n_state = S_IN_SRD;
                end else begin
                    re      = 1'b1;
                    ra      = phys(r_head, r_pos);
                    n_state = S_IN_CMP;
                end
            end

            S_IN_CMP: begin
                if (r_d > rd_del) begin
                    n_d     = r_d - rd_del;
                    n_pos   = r_pos + 1'b1;
                    n_state = S_IN_RD;
                end else begin
                    n_fthr  = rd_thr;
                    n_fdel  = rd_del;
                    n_i     = r_cnt;
                    n_state = S_IN_SRD;
                end
            end

            S_IN_SRD: begin
                if (r_i == r_pos) begin
                    n_state = S_IN_PUT;
                end else begin
                    re      = 1'b1;
                    ra      = phys(r_head, r_i - 1'b1);
                    n_state = S_IN_SWR;
                end
            end

            S_IN_SWR: begin
                we      = 1'b1;
                wa      = phys(r_head, r_i);
                wd      = r_rdat;
                n_i     = r_i - 1'b1;
                n_state = S_IN_SRD;
            end

            S_IN_PUT: begin
                we    = 1'b1;
                wa    = phys(r_head, r_pos);
                wd    = {r_id, r_d};
                n_cnt = r_cnt + 1'b1;
                n_state = (r_pos < r_cnt) ? S_IN_FIX : S_RESP;
            end

            S_IN_FIX: begin
                // The follower keeps only what is left of its delay.
                we      = 1'b1;
                wa      = phys(r_head, r_pos + 1'b1);
                wd      = {r_fthr, r_fdel - r_d};
                n_state = S_RESP;
            end

            S_CA_RD: begin
                if (r_pos == r_cnt) begin
                    n_rst   = ST_NOTFOUND;
                    n_state = S_RESP;
                end else begin
                    re      = 1'b1;
                    ra      = phys(r_head, r_pos);
                    n_state = S_CA_CMP;
                end
            end

            S_CA_CMP: begin
                if (rd_thr == r_id) begin
                    n_fdel  = rd_del;
                    n_i     = r_pos;
                    n_state = S_CA_SRD;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_CA_RD;
                end
            end

            S_CA_SRD: begin
                if ((CW + 1)'(r_i) + 1'b1 >= (CW + 1)'(r_cnt)) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_RESP;
                end else begin
                    re      = 1'b1;
                    ra      = phys(r_head, r_i + 1'b1);
                    n_state = S_CA_SWR;
                end
            end

            S_CA_SWR: begin
                // The successor of the removed entry absorbs its delta.
                we      = 1'b1;
                wa      = phys(r_head, r_i);
                wd      = {rd_thr, (r_i == r_pos) ? rd_del + r_fdel : rd_del};
                n_i     = r_i + 1'b1;
                n_state = S_CA_SRD;
            end

            S_TK_RD: begin
                re      = 1'b1;
                ra      = r_head;
                n_state = S_TK_CHK;
            end

            S_TK_CHK: begin
                if (r_first && rd_del != '0) begin
                    we = 1'b1;
                    wa = r_head;
                    wd = {rd_thr, del_eff};
                end
                n_first = 1'b0;
                if (del_eff != '0) begin
                    if (r_hp) begin
                        n_state = S_TK_FIN;
                    end else begin
                        n_rid   = '0;
                        n_state = S_RESP;
                    end
                end else if (!r_hp || slot_free) begin
                    // A pending release goes out only once we know another follows.
                    if (r_hp) begin
                        n_ov    = 1'b1;
                        n_oid   = r_pend;
                        n_ost   = ST_RELEASED;
                        n_olast = 1'b0;
                    end
                    n_pend = rd_thr;
                    n_hp   = 1'b1;
                    n_head = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_cnt  = r_cnt - 1'b1;
                    n_n    = r_n + 1'b1;
                    if (r_n + 1'b1 < MaxN && r_cnt > CW'(1)) begin
                        n_state = S_TK_RD;
                    end else begin
                        n_state = S_TK_FIN;
                    end
                end
            end

            S_TK_FIN: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_oid   = r_pend;
                    n_ost   = ST_RELEASED;
                    n_olast = 1'b1;
                    n_hp    = 1'b0;
                    n_state = S_IDLE;
                end
            end

            S_RESP: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_oid   = r_rid;
                    n_ost   = r_rst;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/dltq_checker.sv -----
// Port-level checker for the delta-list timer queue, bound to the top level.
// Depends on dltq_pkg and delta_list_timer_queue_top.
module dltq_checker
    import dltq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // The queue works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while an item is in work");

    // Full and not-found answers are always single results.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_FULL || o_m_tuser == ST_NOTFOUND) |-> o_m_tlast)
        else $error("error status on a non-final result");

    // A result that is held off stays valid and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // A non-final result is only ever a release.
    a_release_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser == ST_RELEASED && !o_s_tready)
        else $error("non-final result that is not a release");

endmodule

bind delta_list_timer_queue_top dltq_checker u_dltq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
